// File: design/clcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types and constants of the CR LF line command decoder
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [3:0] SLOT_LINE_LEN   = 4'd10;
    localparam logic [3:0] LEN_MAX         = 4'd15;
    localparam logic [8:0] DEC_SAT         = 9'd256;
    localparam logic [7:0] MAX_FLOOR_RESET = 8'd8;

    typedef enum logic [2:0] {
        EV_READY      = 3'd0,
        EV_SLOT       = 3'd1,
        EV_PARKED     = 3'd2,
        EV_EXITED     = 3'd3,
        EV_DETECTED   = 3'd4,
        EV_BAD_SLOT   = 3'd5,
        EV_BAD_PARKED = 3'd6,
        EV_UNKNOWN    = 3'd7
    } t_event_kind;

    typedef struct packed {
        logic       cr_pending;
        logic [3:0] line_length;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] binary_accum;
        logic       binary_ok;
        logic [8:0] decimal_accum;
        logic       decimal_ok;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        cr_pending:    1'b0,
        line_length:   4'd0,
        first_char:    8'd0,
        second_char:   8'd0,
        binary_accum:  8'd0,
        binary_ok:     1'b1,
        decimal_accum: 9'd0,
        decimal_ok:    1'b1
    };

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  slot_bits;
        logic [7:0]  parked_floor;
    } t_event;

endpackage
`default_nettype wire

// File: design/clcd_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_byte_if
// valid/ready channel carrying one received serial byte
// ----------------------------------------------------------------------------
interface clcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: design/clcd_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_event_if
// valid/ready channel carrying one decoded line event
// ----------------------------------------------------------------------------
interface clcd_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] slot_bits;
    logic [7:0] parked_floor;

    modport source (output valid, output event_kind, output slot_bits,
                    output parked_floor, input ready);
    modport sink   (input valid, input event_kind, input slot_bits,
                    input parked_floor, output ready);
endinterface
`default_nettype wire

// File: design/crlf_line_command_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_line_command_decoder_core
// Frames received serial bytes into CR LF terminated lines and issues one
// event per non-empty line.
//
// i_rx carries one byte per request, o_evt one event (kind, slot byte,
// parked floor) per request; both are valid/ready channels.
// i_cfg_we/i_cfg_wdata write the highest accepted floor (reset value 8);
// write it only while no byte is in flight.
// A byte lands in an input register on acceptance; when it advances, the
// line state update and classification run and the result register is loaded,
// so an event is valid once the LF that ends its line leaves that register.
// Bytes are taken at one per cycle, but for the stall described next.
// When o_evt stalls with an event waiting, bytes that end no line keep
// flowing; a byte that ends a line holds in the input register until the
// waiting event is taken.
// Reset (synchronous, active low) clears the line state, empties both
// registers and restores the floor limit; outside reset no event is lost or repeated.
// ----------------------------------------------------------------------------
module crlf_line_command_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    clcd_byte_if.sink        i_rx,
    clcd_event_if.source     o_evt
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    clcd_pkg::t_event      r_out;
    logic [7:0]            r_max_floor;

    logic                  advance;
    logic                  produce;
    logic                  line_end;
    clcd_pkg::t_line_state line;
    clcd_pkg::t_event      evt;

    assign advance    = r_in_valid && (!r_out_valid || o_evt.ready || !line_end);
    assign produce    = advance && line_end;
    assign i_rx.ready = !r_in_valid || advance;

    clcd_line_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .o_line     (line),
        .o_line_end (line_end)
    );

    clcd_classifier u_classifier (
        .i_line      (line),
        .i_max_floor (r_max_floor),
        .o_event     (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_byte   <= 8'd0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_max_floor <= clcd_pkg::MAX_FLOOR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_floor <= i_cfg_wdata;
            end
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_rx.rx_byte;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
                r_out       <= evt;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_out.kind;
    assign o_evt.slot_bits    = r_out.slot_bits;
    assign o_evt.parked_floor = r_out.parked_floor;

    // slot byte only travels with a slot status event
    a_slot_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind != clcd_pkg::EV_SLOT) |-> (r_out.slot_bits == 8'd0))
        else $error("slot bits set on non-slot event");

    // floor only travels with a parked event, and is never zero there
    a_floor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind != clcd_pkg::EV_PARKED) |-> (r_out.parked_floor == 8'd0))
        else $error("parked floor set on non-parked event");

    a_floor_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == clcd_pkg::EV_PARKED) |-> (r_out.parked_floor != 8'd0))
        else $error("parked event with floor zero");

    // a held byte only waits behind an undelivered event
    a_no_idle_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> r_out_valid && !o_evt.ready && line_end)
        else $error("input register stalled without cause");

    // a produced event is visible the next cycle
    a_produce_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> r_out_valid)
        else $error("event lost after classification");

endmodule
`default_nettype wire

// File: design/clcd_line_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_line_tracker
// CR LF framing and running per-line state (prefix, binary and decimal value)
// ----------------------------------------------------------------------------
module clcd_line_tracker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_byte,
    output clcd_pkg::t_line_state       o_line,
    output logic                        o_line_end
);

    clcd_pkg::t_line_state r_line;
    clcd_pkg::t_line_state n_line;

    function automatic clcd_pkg::t_line_state add_data(
        input clcd_pkg::t_line_state s,
        input logic [7:0]            b
    );
        clcd_pkg::t_line_state r;
        logic                  is_dec;
        logic [11:0]           dec_next;
        r        = s;
        is_dec   = (b >= clcd_pkg::CH_0) && (b <= clcd_pkg::CH_9);
        dec_next = ({3'd0, s.decimal_accum} << 3) + ({3'd0, s.decimal_accum} << 1)
                 + {8'd0, b[3:0]};
        case (s.line_length)
            4'd0: r.first_char  = b;
            4'd1: r.second_char = b;
            default: begin
                if (b == clcd_pkg::CH_0 || b == clcd_pkg::CH_1) begin
                    r.binary_accum = {s.binary_accum[6:0], b[0]};
                end else begin
                    r.binary_ok = 1'b0;
                end
                if (is_dec) begin
                    if (dec_next > {3'd0, clcd_pkg::DEC_SAT}) begin
                        r.decimal_accum = clcd_pkg::DEC_SAT;
                    end else begin
                        r.decimal_accum = dec_next[8:0];
                    end
                end else begin
                    r.decimal_ok = 1'b0;
                end
            end
        endcase
        if (s.line_length != clcd_pkg::LEN_MAX) begin
            r.line_length = s.line_length + 4'd1;
        end
        return r;
    endfunction

    always_comb begin
        clcd_pkg::t_line_state tmp;
        tmp        = r_line;
        n_line     = r_line;
        o_line_end = r_line.cr_pending && (i_byte == clcd_pkg::CH_LF)
                   && (r_line.line_length != 4'd0);
        if (i_step) begin
            if (r_line.cr_pending && i_byte == clcd_pkg::CH_LF) begin
                n_line = clcd_pkg::LINE_CLEAR;
            end else begin
                // lone cr becomes data
                if (tmp.cr_pending) begin
                    tmp.cr_pending = 1'b0;
                    tmp = add_data(tmp, clcd_pkg::CH_CR);
                end
                if (i_byte == clcd_pkg::CH_CR) begin
                    tmp.cr_pending = 1'b1;
                end else begin
                    tmp = add_data(tmp, i_byte);
                end
                n_line = tmp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= clcd_pkg::LINE_CLEAR;
        end else begin
            r_line <= n_line;
        end
    end

    assign o_line = r_line;

endmodule
`default_nettype wire

// File: design/clcd_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcd_classifier
// maps a finished line to its event kind and payload
// ----------------------------------------------------------------------------
module clcd_classifier (
    input  wire clcd_pkg::t_line_state i_line,
    input  wire logic [7:0]            i_max_floor,
    output clcd_pkg::t_event           o_event
);

    logic one_char;
    logic s_prefix;
    logic p_prefix;
    logic floor_ok;

    assign one_char = (i_line.line_length == 4'd1);
    assign s_prefix = (i_line.first_char == clcd_pkg::CH_S)
                   && (i_line.second_char == clcd_pkg::CH_COLON);
    assign p_prefix = (i_line.first_char == clcd_pkg::CH_P)
                   && (i_line.second_char == clcd_pkg::CH_COLON);
    assign floor_ok = (i_line.line_length >= 4'd3) && i_line.decimal_ok
                   && (i_line.decimal_accum != 9'd0)
                   && (i_line.decimal_accum <= {1'b0, i_max_floor});

    always_comb begin
        o_event.kind         = clcd_pkg::EV_UNKNOWN;
        o_event.slot_bits    = 8'd0;
        o_event.parked_floor = 8'd0;
        if (one_char && i_line.first_char == clcd_pkg::CH_R) begin
            o_event.kind = clcd_pkg::EV_READY;
        end else if (i_line.line_length == clcd_pkg::SLOT_LINE_LEN && s_prefix) begin
            if (i_line.binary_ok) begin
                o_event.kind      = clcd_pkg::EV_SLOT;
                o_event.slot_bits = i_line.binary_accum;
            end else begin
                o_event.kind = clcd_pkg::EV_BAD_SLOT;
            end
        end else if (i_line.line_length >= 4'd2 && p_prefix) begin
            if (floor_ok) begin
                o_event.kind         = clcd_pkg::EV_PARKED;
                o_event.parked_floor = i_line.decimal_accum[7:0];
            end else begin
                o_event.kind = clcd_pkg::EV_BAD_PARKED;
            end
        end else if (one_char && i_line.first_char == clcd_pkg::CH_E) begin
            o_event.kind = clcd_pkg::EV_EXITED;
        end else if (one_char && i_line.first_char == clcd_pkg::CH_D) begin
            o_event.kind = clcd_pkg::EV_DETECTED;
        end
    end

endmodule
`default_nettype wire

// File: tb/sv/line_event_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_event_board_pkg
// Scoreboard for the CR LF line command decoder. It keeps its own copy of the
// line framing state and the floor limit. For every accepted byte that ends a
// non-empty line it predicts the line event, and it checks each event taken from
// the block against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
package line_event_board_pkg;
    import clcd_pkg::*;

    class line_event_board;
        bit [7:0] floor_limit;
        bit       cr_held;
        bit [3:0] line_len;
        bit [7:0] lead_char;
        bit [7:0] tag_char;
        bit [7:0] slot_accum;
        bit       slot_digits_ok;
        bit [8:0] floor_accum;
        bit       floor_digits_ok;
        t_event   expected_events[$];
        int       mismatches;
        int       events_checked;
        int       bytes_taken;
        int       kind_hits[8];

        function new();
            floor_limit = MAX_FLOOR_RESET;
            clear_line();
        endfunction

        function void set_floor_limit(bit [7:0] limit);
            floor_limit = limit;
        endfunction

        function void clear_line();
            cr_held         = 1'b0;
            line_len        = 4'd0;
            lead_char       = 8'd0;
            tag_char        = 8'd0;
            slot_accum      = 8'd0;
            slot_digits_ok  = 1'b1;
            floor_accum     = 9'd0;
            floor_digits_ok = 1'b1;
        endfunction

        function void append_data(bit [7:0] b);
            bit [31:0] v;
            if (line_len == 4'd0) begin
                lead_char = b;
            end else if (line_len == 4'd1) begin
                tag_char = b;
            end else begin
                if (b == CH_0 || b == CH_1) begin
                    slot_accum = {slot_accum[6:0], b[0]};
                end else begin
                    slot_digits_ok = 1'b0;
                end
                if (b >= CH_0 && b <= CH_9) begin
                    v = 32'(floor_accum) * 32'd10 + 32'(b) - 32'(CH_0);
                    floor_accum = (v > 32'(DEC_SAT)) ? DEC_SAT : v[8:0];
                end else begin
                    floor_digits_ok = 1'b0;
                end
            end
            if (line_len != LEN_MAX) begin
                line_len++;
            end
        endfunction

        function t_event classify_line();
            t_event ev;
            ev.kind         = EV_UNKNOWN;
            ev.slot_bits    = 8'd0;
            ev.parked_floor = 8'd0;
            if (line_len == 4'd1 && lead_char == CH_R) begin
                ev.kind = EV_READY;
            end else if (line_len == SLOT_LINE_LEN && lead_char == CH_S
                         && tag_char == CH_COLON) begin
                if (slot_digits_ok) begin
                    ev.kind      = EV_SLOT;
                    ev.slot_bits = slot_accum;
                end else begin
                    ev.kind = EV_BAD_SLOT;
                end
            end else if (line_len >= 4'd2 && lead_char == CH_P && tag_char == CH_COLON) begin
                if (line_len >= 4'd3 && floor_digits_ok && floor_accum >= 9'd1
                    && floor_accum <= {1'b0, floor_limit}) begin
                    ev.kind         = EV_PARKED;
                    ev.parked_floor = floor_accum[7:0];
                end else begin
                    ev.kind = EV_BAD_PARKED;
                end
            end else if (line_len == 4'd1 && lead_char == CH_E) begin
                ev.kind = EV_EXITED;
            end else if (line_len == 4'd1 && lead_char == CH_D) begin
                ev.kind = EV_DETECTED;
            end
            return ev;
        endfunction

        function void take_byte(bit [7:0] b);
            bytes_taken++;
            if (cr_held && b == CH_LF) begin
                if (line_len != 4'd0) begin
                    expected_events.push_back(classify_line());
                end
                clear_line();
                return;
            end
            if (cr_held) begin
                cr_held = 1'b0;
                append_data(CH_CR);
            end
            if (b == CH_CR) begin
                cr_held = 1'b1;
            end else begin
                append_data(b);
            end
        endfunction

        function void check_event(logic [2:0] kind, logic [7:0] slot, logic [7:0] floor_no);
            t_event want;
            if (expected_events.size() == 0) begin
                $error("event with none expected: event_kind %0d slot_bits %0d parked_floor %0d",
                       kind, slot, floor_no);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            kind_hits[int'(want.kind)]++;
            if (kind !== want.kind) begin
                $error("event_kind expected %0d actual %0d", want.kind, kind);
                mismatches++;
            end
            if (slot !== want.slot_bits) begin
                $error("slot_bits expected %0d actual %0d", want.slot_bits, slot);
                mismatches++;
            end
            if (floor_no !== want.parked_floor) begin
                $error("parked_floor expected %0d actual %0d", want.parked_floor, floor_no);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for crlf_line_command_decoder_core. A short directed line set is
// followed by random line traffic under several floor limits, mostly
// well-formed commands with random content plus broken lines and noise. Both
// channels idle at random and the event side holds off once for a long
// stretch so the input stalls.
// ----------------------------------------------------------------------------
module tb;
    import clcd_pkg::*;
    import line_event_board_pkg::*;

    localparam int RUN_LIMIT       = 100000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PHASE_BYTES     = 80;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    clcd_byte_if  rx_ch ();
    clcd_event_if evt_ch ();

    line_event_board board = new();

    logic [7:0] line_bytes[$];
    int         bytes_sent     = 0;
    int         cycle_count    = 0;
    int         limits_written = 0;
    bit         calm           = 1'b0;
    bit         hold_off_req   = 1'b0;
    int         hold_offs_done = 0;

    crlf_line_command_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_ch),
        .o_evt       (evt_ch)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count == RUN_LIMIT);
        $display("crlf_line_command_decoder_core regression: fail");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                board.take_byte(rx_ch.rx_byte);
            end
            if (evt_ch.valid && evt_ch.ready) begin
                board.check_event(evt_ch.event_kind, evt_ch.slot_bits, evt_ch.parked_floor);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    initial begin : event_sink
        evt_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                evt_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_offs_done++;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                evt_ch.ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
            end else begin
                evt_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void put_number(int unsigned v, int zeros);
        logic [7:0] digits[$];
        repeat (zeros) line_bytes.push_back(CH_0);
        do begin
            digits.push_front(CH_0 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) begin
            line_bytes.push_back(digits[i]);
        end
    endfunction

    function automatic logic [7:0] pick_junk();
        case ($urandom_range(0, 4))
            0: return " ";
            1: return "+";
            2: return "-";
            3: return 8'h09;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_random_line();
        int          pick;
        int          n;
        int          bad_at;
        int          junk;
        int unsigned val;
        logic [7:0]  lim;
        lim  = board.floor_limit;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 3))
                0: line_bytes.push_back(CH_R);
                1: line_bytes.push_back(CH_E);
                2: line_bytes.push_back(CH_D);
                default: line_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 4) == 0) begin
                line_bytes.push_back(8'($urandom_range(32, 126)));
            end
        end else if (pick < 32) begin
            line_bytes.push_back(CH_S);
            line_bytes.push_back(($urandom_range(0, 9) == 0)
                                 ? 8'($urandom_range(32, 126)) : CH_COLON);
            n      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 8;
            bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : -1;
            for (int i = 0; i < n; i++) begin
                if (i == bad_at) begin
                    line_bytes.push_back(pick_junk());
                end else begin
                    line_bytes.push_back($urandom_range(0, 1) ? CH_1 : CH_0);
                end
            end
        end else if (pick < 58) begin
            put_text("P:");
            junk = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            case ($urandom_range(0, 9))
                0: val = 0;
                1: val = 32'(lim) + 1;
                2: val = $urandom_range(256, 99999);
                3, 4: val = $urandom_range(0, 300);
                default: val = (lim == 8'd0) ? $urandom_range(1, 9) : $urandom_range(1, lim);
            endcase
            if (junk == 1) begin
                line_bytes.push_back(pick_junk());
            end
            // parked line with no digits now and then
            if ($urandom_range(0, 11) != 0) begin
                put_number(val, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end
            if (junk == 2) begin
                line_bytes.push_back(pick_junk());
            end
        end else if (pick < 66) begin
            // empty line or a lone cr before the line end
            if ($urandom_range(0, 2) == 0) begin
                line_bytes.push_back(CH_CR);
            end
        end else if (pick < 78) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0, 1: line_bytes.push_back(CH_CR);
                    2: line_bytes.push_back(CH_R);
                    3: line_bytes.push_back(CH_P);
                    4: line_bytes.push_back(CH_COLON);
                    default: line_bytes.push_back(CH_1);
                endcase
            end
        end else if (pick < 88) begin
            n = $urandom_range(11, 24);
            if ($urandom_range(0, 1)) begin
                put_text("P:");
                repeat (n) line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end else begin
                repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
                return;
            end
        end
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
    endfunction

    task automatic send_bytes();
        int gap;
        foreach (line_bytes[i]) begin
            gap = pick_gap();
            if (gap != 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= line_bytes[i];
            @(posedge clk);
            while (!rx_ch.ready) @(posedge clk);
            bytes_sent++;
        end
        line_bytes.delete();
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_floor_limit(input logic [7:0] limit);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_floor_limit(limit);
        limits_written++;
    endtask

    initial begin : stimulus
        logic [7:0] limits[5];
        int         phase_end;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 8'd0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        limits = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)), MAX_FLOOR_RESET};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines under the reset floor limit
        put_text("R");
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        put_text("E");
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        put_text("D");
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        put_text("P:8");
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        put_text("P:");
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
        send_bytes();

        for (int p = 0; p < 5; p++) begin
            write_floor_limit(limits[p]);
            calm = (p == 3);
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                build_random_line();
                send_bytes();
            end
        end

        calm = 1'b1;
        wait_idle();
        repeat (10) @(posedge clk);

        $display("run: %0d bytes sent, %0d line events checked, %0d floor limits, %0d hold-offs",
                 bytes_sent, board.events_checked, limits_written, hold_offs_done);
        $display("kinds: ready %0d slot %0d parked %0d exit %0d detect %0d bad slot %0d %s %0d %s %0d",
                 board.kind_hits[0], board.kind_hits[1], board.kind_hits[2],
                 board.kind_hits[3], board.kind_hits[4], board.kind_hits[5],
                 "bad parked", board.kind_hits[6], "unknown", board.kind_hits[7]);
        if (board.mismatches == 0) begin
            $display("crlf_line_command_decoder_core regression: pass");
        end else begin
            $display("crlf_line_command_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
